// ===== hdl/wsp_pkg.sv =====
// Shared types, widths and helpers for the wall segment to prism block.
`timescale 1ns / 1ps
package wsp_pkg;

   localparam int COORD_W  = 32;
   localparam int THICK_W  = 22;
   localparam int DIFF_W   = COORD_W + 1;          // exact endpoint difference
   localparam int SQ_W     = 2 * COORD_W;          // one square, kept modulo 2^64
   localparam int RAD_W    = SQ_W + 2;             // radicand, even bit count
   localparam int ROOT_W   = RAD_W / 2;            // one root bit per stage
   localparam int SREM_W   = ROOT_W + 2;           // square root remainder
   localparam int DEN_W    = ROOT_W + 1;           // twice the length
   localparam int PROD_W   = THICK_W + DIFF_W;     // thickness times difference
   localparam int OFS_W    = PROD_W + 2;           // signed offset and corner sums
   localparam int WALL_HEIGHT_RESET = 163840;

   typedef struct packed {
      logic signed [COORD_W-1:0] sx;
      logic signed [COORD_W-1:0] sy;
      logic signed [COORD_W-1:0] ex;
      logic signed [COORD_W-1:0] ey;
      logic [THICK_W-1:0]        thick;
      logic [DIFF_W-1:0]         adx;
      logic [DIFF_W-1:0]         ady;
      logic                      dx_neg;
      logic                      dy_neg;
   } seg_type;

   typedef struct packed {
      logic signed [COORD_W-1:0] sx;
      logic signed [COORD_W-1:0] sy;
      logic signed [COORD_W-1:0] ex;
      logic signed [COORD_W-1:0] ey;
      logic                      degen;
      logic                      ox_neg;
      logic                      oy_neg;
   } ofs_type;

   function automatic logic [COORD_W-1:0] sat_coord(input logic signed [OFS_W-1:0] v);
      logic signed [OFS_W-1:0] hi_lim;
      logic signed [OFS_W-1:0] lo_lim;
      hi_lim = OFS_W'(2147483647);
      lo_lim = -OFS_W'(64'sd2147483648);
      if (v > hi_lim) return 32'h7FFF_FFFF;
      else if (v < lo_lim) return 32'h8000_0000;
      else return v[COORD_W-1:0];
   endfunction

endpackage

// ===== hdl/wsp_div.sv =====
// Pipelined restoring divider, one quotient bit per stage.
`timescale 1ns / 1ps
module wsp_div import wsp_pkg::*; #(
   parameter int NUM_W = PROD_W,
   parameter int DEN_W_P = DEN_W
) (
   input  logic               clock,
   input  logic               en,
   input  logic [NUM_W-1:0]   num,
   input  logic [DEN_W_P-1:0] den,
   output logic [NUM_W-1:0]   quo
);

   logic [NUM_W-1:0]   n_ff   [NUM_W];
   logic [NUM_W-1:0]   q_ff   [NUM_W];
   logic [DEN_W_P-1:0] d_ff   [NUM_W];
   logic [DEN_W_P-1:0] rem_ff [NUM_W];
   logic [NUM_W-1:0]   n_in   [NUM_W];
   logic [NUM_W-1:0]   q_in   [NUM_W];
   logic [DEN_W_P-1:0] d_in   [NUM_W];
   logic [DEN_W_P-1:0] rem_in [NUM_W];

   always_comb begin
      for (int j = 0; j < NUM_W; j++) begin
         logic [NUM_W-1:0]   n_p;
         logic [NUM_W-1:0]   q_p;
         logic [DEN_W_P-1:0] d_p;
         logic [DEN_W_P-1:0] r_p;
         logic [DEN_W_P:0]   r;
         if (j == 0) begin
            n_p = num;
            q_p = '0;
            d_p = den;
            r_p = '0;
         end else begin
            n_p = n_ff[j-1];
            q_p = q_ff[j-1];
            d_p = d_ff[j-1];
            r_p = rem_ff[j-1];
         end
         r = {r_p, n_p[NUM_W-1]};
         if (r >= {1'b0, d_p}) begin
            r = r - {1'b0, d_p};
            q_in[j] = {q_p[NUM_W-2:0], 1'b1};
         end else begin
            q_in[j] = {q_p[NUM_W-2:0], 1'b0};
         end
         rem_in[j] = r[DEN_W_P-1:0];
         n_in[j]   = {n_p[NUM_W-2:0], 1'b0};
         d_in[j]   = d_p;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int j = 0; j < NUM_W; j++) begin
            n_ff[j]   <= n_in[j];
            q_ff[j]   <= q_in[j];
            d_ff[j]   <= d_in[j];
            rem_ff[j] <= rem_in[j];
         end
      end
   end

   assign quo = q_ff[NUM_W-1];

endmodule

// ===== hdl/wall_segment_to_prism.sv =====
// Top level: expands a wall segment into the eight vertices of its prism.
`timescale 1ns / 1ps
// Each segment leaves as eight vertex words from a serializer, and that serializer
// sets the rate at which segments are accepted: it loads a segment only when empty
// or as the last word of its current one is taken. Ahead of it sits a pipeline of
// 94 stages (endpoint difference, absolute value, squares, sum, 33 square root
// stages, products, 55 divider stages, offset), and up to 95 segments can be in
// flight, one of them in the serializer.
// The pipeline advances as one; it holds while its last stage waits for the
// serializer.
// The wall height register is written through a port that is always ready.
module wall_segment_to_prism import wsp_pkg::*; (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_stall,
   input  logic signed [COORD_W-1:0] req_start_x,
   input  logic signed [COORD_W-1:0] req_start_y,
   input  logic signed [COORD_W-1:0] req_end_x,
   input  logic signed [COORD_W-1:0] req_end_y,
   input  logic [THICK_W-1:0]        req_wall_thickness,
   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   output logic [2:0]                rsp_corner_index,
   output logic signed [COORD_W-1:0] rsp_vertex_x,
   output logic signed [COORD_W-1:0] rsp_vertex_y,
   output logic [THICK_W-1:0]        rsp_vertex_z,
   output logic                      rsp_degenerate,
   output logic                      rsp_last_vertex,
   input  logic                      csr_valid,
   output logic                      csr_ready,
   input  logic [THICK_W-1:0]        csr_wall_height
);

   logic adv;
   logic load_ok;

   logic [THICK_W-1:0] height_ff;

   // difference stage
   logic                      v1_ff;
   logic signed [COORD_W-1:0] sx1_ff, sy1_ff, ex1_ff, ey1_ff;
   logic [THICK_W-1:0]        t1_ff;
   logic signed [DIFF_W-1:0]  dx1_ff, dy1_ff;

   // absolute value, squares, sum
   logic            v2_ff, v3_ff, v4_ff;
   seg_type         p2_ff, p3_ff, p4_ff, p2_in;
   logic [SQ_W-1:0] a3_ff, b3_ff;
   logic [SQ_W-1:0] a3_in, b3_in;
   logic [RAD_W-1:0] rad4_ff;

   // square root stages
   logic              sq_v_ff    [ROOT_W];
   seg_type           sq_p_ff    [ROOT_W];
   logic [RAD_W-1:0]  sq_rad_ff  [ROOT_W];
   logic [ROOT_W-1:0] sq_root_ff [ROOT_W];
   logic [SREM_W-1:0] sq_rem_ff  [ROOT_W];
   logic [RAD_W-1:0]  sq_rad_in  [ROOT_W];
   logic [ROOT_W-1:0] sq_root_in [ROOT_W];
   logic [SREM_W-1:0] sq_rem_in  [ROOT_W];

   // products
   logic              vp_ff;
   ofs_type           pp_ff;
   logic [PROD_W-1:0] nx_ff, ny_ff;
   logic [DEN_W-1:0]  den_ff;
   seg_type           sq_last;
   logic [ROOT_W-1:0] len;

   // divider delay line
   logic              dv_v_ff [PROD_W];
   ofs_type           dv_p_ff [PROD_W];
   logic [PROD_W-1:0] qx, qy;

   // offset stage
   logic                    vf_ff;
   ofs_type                 pf_ff;
   logic signed [OFS_W-1:0] ox_ff, oy_ff;
   ofs_type                 dv_last;

   // serializer
   logic               ser_v_ff;
   logic [2:0]         cnt_ff;
   logic               degen_ff;
   logic [COORD_W-1:0] cx_ff [4];
   logic [COORD_W-1:0] cy_ff [4];
   logic [COORD_W-1:0] cx_in [4];
   logic [COORD_W-1:0] cy_in [4];

   assign load_ok   = !ser_v_ff || (!rsp_stall && cnt_ff == 3'd7);
   assign adv       = !vf_ff || load_ok;
   assign req_stall = !adv;
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         height_ff <= THICK_W'(WALL_HEIGHT_RESET);
      end else if (csr_valid) begin
         height_ff <= csr_wall_height;
      end
   end

   // valid bits of the whole pipeline
   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
         vp_ff <= 1'b0;
         vf_ff <= 1'b0;
         for (int j = 0; j < ROOT_W; j++) sq_v_ff[j] <= 1'b0;
         for (int j = 0; j < PROD_W; j++) dv_v_ff[j] <= 1'b0;
      end else if (adv) begin
         v1_ff <= req_valid;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
         v4_ff <= v3_ff;
         sq_v_ff[0] <= v4_ff;
         for (int j = 1; j < ROOT_W; j++) sq_v_ff[j] <= sq_v_ff[j-1];
         vp_ff <= sq_v_ff[ROOT_W-1];
         dv_v_ff[0] <= vp_ff;
         for (int j = 1; j < PROD_W; j++) dv_v_ff[j] <= dv_v_ff[j-1];
         vf_ff <= dv_v_ff[PROD_W-1];
      end
   end

   always_comb begin
      p2_in.sx     = sx1_ff;
      p2_in.sy     = sy1_ff;
      p2_in.ex     = ex1_ff;
      p2_in.ey     = ey1_ff;
      p2_in.thick  = t1_ff;
      p2_in.dx_neg = dx1_ff[DIFF_W-1];
      p2_in.dy_neg = dy1_ff[DIFF_W-1];
      p2_in.adx    = dx1_ff[DIFF_W-1] ? DIFF_W'(-dx1_ff) : DIFF_W'(dx1_ff);
      p2_in.ady    = dy1_ff[DIFF_W-1] ? DIFF_W'(-dy1_ff) : DIFF_W'(dy1_ff);
   end

   // a difference of exactly 2^32 squares to 2^64, which wraps to zero
   always_comb begin
      a3_in = p2_ff.adx[DIFF_W-1] ? '0 :
              SQ_W'(p2_ff.adx[COORD_W-1:0]) * SQ_W'(p2_ff.adx[COORD_W-1:0]);
      b3_in = p2_ff.ady[DIFF_W-1] ? '0 :
              SQ_W'(p2_ff.ady[COORD_W-1:0]) * SQ_W'(p2_ff.ady[COORD_W-1:0]);
   end

   always_comb begin
      for (int j = 0; j < ROOT_W; j++) begin
         logic [RAD_W-1:0]  rad_p;
         logic [ROOT_W-1:0] root_p;
         logic [SREM_W-1:0] rem_p;
         logic [SREM_W+1:0] r;
         logic [SREM_W+1:0] trial;
         if (j == 0) begin
            rad_p  = rad4_ff;
            root_p = '0;
            rem_p  = '0;
         end else begin
            rad_p  = sq_rad_ff[j-1];
            root_p = sq_root_ff[j-1];
            rem_p  = sq_rem_ff[j-1];
         end
         r     = {rem_p, rad_p[RAD_W-1 -: 2]};
         trial = {1'b0, root_p, 2'b01};
         if (r >= trial) begin
            r = r - trial;
            sq_root_in[j] = {root_p[ROOT_W-2:0], 1'b1};
         end else begin
            sq_root_in[j] = {root_p[ROOT_W-2:0], 1'b0};
         end
         sq_rem_in[j] = r[SREM_W-1:0];
         sq_rad_in[j] = {rad_p[RAD_W-3:0], 2'b00};
      end
   end

   assign sq_last = sq_p_ff[ROOT_W-1];
   assign len     = sq_root_ff[ROOT_W-1];
   assign dv_last = dv_p_ff[PROD_W-1];

   always_comb begin
      for (int k = 0; k < 4; k++) begin
         logic signed [OFS_W-1:0] px;
         logic signed [OFS_W-1:0] py;
         logic signed [OFS_W-1:0] ox;
         logic signed [OFS_W-1:0] oy;
         px = (k < 2) ? OFS_W'(pf_ff.sx) : OFS_W'(pf_ff.ex);
         py = (k < 2) ? OFS_W'(pf_ff.sy) : OFS_W'(pf_ff.ey);
         ox = (k == 1 || k == 2) ? -ox_ff : ox_ff;
         oy = (k == 1 || k == 2) ? -oy_ff : oy_ff;
         cx_in[k] = sat_coord(px + ox);
         cy_in[k] = sat_coord(py + oy);
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (adv) begin
         sx1_ff <= req_start_x;
         sy1_ff <= req_start_y;
         ex1_ff <= req_end_x;
         ey1_ff <= req_end_y;
         t1_ff  <= req_wall_thickness;
         dx1_ff <= DIFF_W'(req_end_x) - DIFF_W'(req_start_x);
         dy1_ff <= DIFF_W'(req_end_y) - DIFF_W'(req_start_y);
         p2_ff  <= p2_in;
         p3_ff  <= p2_ff;
         a3_ff  <= a3_in;
         b3_ff  <= b3_in;
         p4_ff  <= p3_ff;
         rad4_ff <= {1'b0, {1'b0, a3_ff} + {1'b0, b3_ff}};
         for (int j = 0; j < ROOT_W; j++) begin
            sq_p_ff[j]    <= (j == 0) ? p4_ff : sq_p_ff[j-1];
            sq_rad_ff[j]  <= sq_rad_in[j];
            sq_root_ff[j] <= sq_root_in[j];
            sq_rem_ff[j]  <= sq_rem_in[j];
         end
         pp_ff.sx     <= sq_last.sx;
         pp_ff.sy     <= sq_last.sy;
         pp_ff.ex     <= sq_last.ex;
         pp_ff.ey     <= sq_last.ey;
         pp_ff.degen  <= (len == '0);
         pp_ff.ox_neg <= !sq_last.dy_neg;   // x offset follows -dy
         pp_ff.oy_neg <= sq_last.dx_neg;
         nx_ff  <= PROD_W'(sq_last.thick) * PROD_W'(sq_last.ady);
         ny_ff  <= PROD_W'(sq_last.thick) * PROD_W'(sq_last.adx);
         den_ff <= {len, 1'b0};
         dv_p_ff[0] <= pp_ff;
         for (int j = 1; j < PROD_W; j++) dv_p_ff[j] <= dv_p_ff[j-1];
         pf_ff <= dv_last;
         // zero length: drop the offset
         if (dv_last.degen) begin
            ox_ff <= '0;
            oy_ff <= '0;
         end else begin
            ox_ff <= dv_last.ox_neg ? -OFS_W'(qx) : OFS_W'(qx);
            oy_ff <= dv_last.oy_neg ? -OFS_W'(qy) : OFS_W'(qy);
         end
      end
   end

   wsp_div #(.NUM_W(PROD_W), .DEN_W_P(DEN_W)) u_div_x (
      .clock (clock),
      .en    (adv),
      .num   (nx_ff),
      .den   (den_ff),
      .quo   (qx)
   );

   wsp_div #(.NUM_W(PROD_W), .DEN_W_P(DEN_W)) u_div_y (
      .clock (clock),
      .en    (adv),
      .num   (ny_ff),
      .den   (den_ff),
      .quo   (qy)
   );

   // serializer: eight vertex words per segment
   always_ff @(posedge clock) begin
      if (reset) begin
         ser_v_ff <= 1'b0;
         cnt_ff   <= '0;
      end else if (load_ok) begin
         ser_v_ff <= vf_ff;
         cnt_ff   <= '0;
      end else if (!rsp_stall) begin
         cnt_ff <= cnt_ff + 3'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (load_ok) begin
         degen_ff <= pf_ff.degen;
         for (int k = 0; k < 4; k++) begin
            cx_ff[k] <= cx_in[k];
            cy_ff[k] <= cy_in[k];
         end
      end
   end

   assign rsp_valid        = ser_v_ff;
   assign rsp_corner_index = cnt_ff;
   assign rsp_vertex_x     = cx_ff[cnt_ff[1:0]];
   assign rsp_vertex_y     = cy_ff[cnt_ff[1:0]];
   assign rsp_vertex_z     = cnt_ff[2] ? height_ff : '0;
   assign rsp_degenerate   = degen_ff;
   assign rsp_last_vertex  = (cnt_ff == 3'd7);

endmodule

// ===== hdl/wsp_checker.sv =====
// Port checker for the wall segment to prism block, bound to the top level.
`timescale 1ns / 1ps
module wsp_checker import wsp_pkg::*; (
   input logic               clock,
   input logic               reset,
   input logic               rsp_valid,
   input logic               rsp_stall,
   input logic [2:0]         rsp_corner_index,
   input logic [THICK_W-1:0] rsp_vertex_z,
   input logic               rsp_degenerate,
   input logic               rsp_last_vertex
);

   a_last_is_eighth: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_last_vertex == (rsp_corner_index == 3'd7)))
      else $error("last_vertex does not mark the eighth vertex");

   a_run_continues: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_stall && !rsp_last_vertex) |=>
         (rsp_valid && rsp_corner_index == $past(rsp_corner_index) + 3'd1
          && $stable(rsp_degenerate)))
      else $error("vertex run broken before its eighth word");

   a_bottom_flat: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_corner_index[2]) |-> (rsp_vertex_z == '0))
      else $error("bottom corner with nonzero z");

   a_stall_holds: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> (rsp_valid && $stable(rsp_corner_index)))
      else $error("stalled word changed");

endmodule

bind wall_segment_to_prism wsp_checker u_wsp_checker (
   .clock            (clock),
   .reset            (reset),
   .rsp_valid        (rsp_valid),
   .rsp_stall        (rsp_stall),
   .rsp_corner_index (rsp_corner_index),
   .rsp_vertex_z     (rsp_vertex_z),
   .rsp_degenerate   (rsp_degenerate),
   .rsp_last_vertex  (rsp_last_vertex)
);

// ===== dv/wall_segment_checker.sv =====
// Checker for the wall segment prism expander: predicts the eight vertex words of each segment.
`timescale 1ns / 1ps
module wall_segment_checker import wsp_pkg::*; (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   input  logic                      req_stall,
   input  logic signed [COORD_W-1:0] req_start_x,
   input  logic signed [COORD_W-1:0] req_start_y,
   input  logic signed [COORD_W-1:0] req_end_x,
   input  logic signed [COORD_W-1:0] req_end_y,
   input  logic [THICK_W-1:0]        req_wall_thickness,
   input  logic                      rsp_valid,
   input  logic                      rsp_stall,
   input  logic [2:0]                rsp_corner_index,
   input  logic signed [COORD_W-1:0] rsp_vertex_x,
   input  logic signed [COORD_W-1:0] rsp_vertex_y,
   input  logic [THICK_W-1:0]        rsp_vertex_z,
   input  logic                      rsp_degenerate,
   input  logic                      rsp_last_vertex,
   input  logic                      csr_valid,
   input  logic                      csr_ready,
   input  logic [THICK_W-1:0]        csr_wall_height,
   output int                        mismatches,
   output int                        vertices_pending
);

   typedef struct {
      logic [2:0]         corner;
      logic [COORD_W-1:0] x;
      logic [COORD_W-1:0] y;
      logic [THICK_W-1:0] z;
      logic               degen;
      logic               last;
   } vertex_type;

   vertex_type         vertex_q[$];
   logic [THICK_W-1:0] height_mirror;

   assign vertices_pending = vertex_q.size();

   // floor of the square root of a 66-bit radicand, two bits per step
   function automatic logic [33:0] floor_sqrt(input logic [65:0] rad);
      logic [69:0] rem;
      logic [69:0] root;
      logic [69:0] trial;
      rem  = '0;
      root = '0;
      for (int i = 32; i >= 0; i--) begin
         rem   = (rem << 2) | 70'(rad[2*i+1 -: 2]);
         trial = (root << 2) | 70'd1;
         if (rem >= trial) begin
            rem  = rem - trial;
            root = (root << 1) | 70'd1;
         end else begin
            root = root << 1;
         end
      end
      return root[33:0];
   endfunction

   function automatic logic [COORD_W-1:0] clamp32(input longint v);
      if (v > 64'sd2147483647) return 32'h7FFF_FFFF;
      if (v < -64'sd2147483648) return 32'h8000_0000;
      return v[31:0];
   endfunction

   task automatic expand_segment(input logic signed [31:0] sx, input logic signed [31:0] sy,
                                 input logic signed [31:0] ex, input logic signed [31:0] ey,
                                 input logic [THICK_W-1:0] thick);
      longint      dx, dy, ox, oy;
      longint      cx[4], cy[4];
      logic [63:0] adx, ady, q, den;
      logic [65:0] rad;
      logic [33:0] len;
      vertex_type  v;
      dx  = longint'(ex) - longint'(sx);
      dy  = longint'(ey) - longint'(sy);
      adx = (dx < 0) ? -dx : dx;
      ady = (dy < 0) ? -dy : dy;
      rad = 66'(adx) * 66'(adx) + 66'(ady) * 66'(ady);
      len = floor_sqrt(rad);
      ox  = 0;
      oy  = 0;
      if (len != 0) begin
         den = 64'(len) << 1;
         // offset along (-dy, dx), truncated toward zero
         q  = (64'(thick) * ady) / den;
         ox = (dy > 0) ? -longint'(q) : longint'(q);
         q  = (64'(thick) * adx) / den;
         oy = (dx < 0) ? -longint'(q) : longint'(q);
      end
      cx[0] = longint'(sx) + ox; cy[0] = longint'(sy) + oy;
      cx[1] = longint'(sx) - ox; cy[1] = longint'(sy) - oy;
      cx[2] = longint'(ex) - ox; cy[2] = longint'(ey) - oy;
      cx[3] = longint'(ex) + ox; cy[3] = longint'(ey) + oy;
      for (int k = 0; k < 8; k++) begin
         v.corner = 3'(k);
         v.x      = clamp32(cx[k % 4]);
         v.y      = clamp32(cy[k % 4]);
         v.z      = (k < 4) ? '0 : height_mirror;
         v.degen  = (len == 0);
         v.last   = (k == 7);
         vertex_q.push_back(v);
      end
   endtask

   always @(posedge clock) begin
      vertex_type want;
      if (reset) begin
         height_mirror <= THICK_W'(WALL_HEIGHT_RESET);
         mismatches = 0;
      end else begin
         if (csr_valid && csr_ready) height_mirror <= csr_wall_height;
         if (req_valid && !req_stall)
            expand_segment(req_start_x, req_start_y, req_end_x, req_end_y, req_wall_thickness);
         if (rsp_valid && !rsp_stall) begin
            if (vertex_q.size() == 0) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("vertex word with nothing expected at %0t", $realtime);
            end else begin
               want = vertex_q.pop_front();
               if (rsp_corner_index !== want.corner || rsp_vertex_x !== want.x ||
                   rsp_vertex_y !== want.y || rsp_vertex_z !== want.z ||
                   rsp_degenerate !== want.degen || rsp_last_vertex !== want.last) begin
                  mismatches++;
                  if (mismatches <= 10)
                     $display({"vertex mismatch at %0t: exp idx %0d x %h y %h z %h dg %b",
                               " lst %b, got idx %0d x %h y %h z %h dg %b lst %b"},
                              $realtime, want.corner, want.x, want.y, want.z, want.degen,
                              want.last, rsp_corner_index, rsp_vertex_x, rsp_vertex_y,
                              rsp_vertex_z, rsp_degenerate, rsp_last_vertex);
               end
            end
         end
      end
   end

endmodule

// ===== dv/tb_wall_segment_to_prism.sv =====
// Testbench top: drives segments and height writes into the prism expander and reports the verdict.
`timescale 1ns / 1ps
module tb_wall_segment_to_prism;
   import wsp_pkg::*;

   logic                      clock;
   logic                      reset;
   logic                      req_valid;
   logic                      req_stall;
   logic signed [COORD_W-1:0] req_start_x, req_start_y, req_end_x, req_end_y;
   logic [THICK_W-1:0]        req_wall_thickness;
   logic                      rsp_valid;
   logic                      rsp_stall;
   logic [2:0]                rsp_corner_index;
   logic signed [COORD_W-1:0] rsp_vertex_x, rsp_vertex_y;
   logic [THICK_W-1:0]        rsp_vertex_z;
   logic                      rsp_degenerate, rsp_last_vertex;
   logic                      csr_valid;
   logic                      csr_ready;
   logic [THICK_W-1:0]        csr_wall_height;
   int                        mismatches;
   int                        vertices_pending;
   logic                      hold_output;

   localparam int DRAIN_CYCLES = 150;

   wall_segment_to_prism uut (.*);
   wall_segment_checker  chk (.*);

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   initial begin
      #(12ns * 600000);
      $display("tb_wall_segment_to_prism NOT OK");
      $finish;
   end

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 60) return 0;
      if (r < 94) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   // receiver: random stalls, plus one long hold-off on request
   initial begin
      int n;
      bit held;
      held      = 1'b0;
      rsp_stall = 1'b0;
      @(negedge reset);
      forever begin
         if (hold_output && !held) begin
            rsp_stall <= 1'b1;
            repeat (400) @(posedge clock);
            held = 1'b1;
         end else begin
            n = pick_gap();
            rsp_stall <= (n != 0);
            repeat (n == 0 ? $urandom_range(1, 12) : n) @(posedge clock);
         end
      end
   end

   task automatic send_segment(input logic [31:0] sx, input logic [31:0] sy,
                               input logic [31:0] ex, input logic [31:0] ey,
                               input logic [THICK_W-1:0] thick);
      int n;
      req_valid          <= 1'b1;
      req_start_x        <= sx;
      req_start_y        <= sy;
      req_end_x          <= ex;
      req_end_y          <= ey;
      req_wall_thickness <= thick;
      do @(posedge clock); while (req_stall);
      n = pick_gap();
      if (n != 0) begin
         req_valid <= 1'b0;
         repeat (n) @(posedge clock);
      end
   endtask

   task automatic settle_and_write(input logic [THICK_W-1:0] height);
      req_valid <= 1'b0;
      @(posedge clock);
      wait (vertices_pending == 0);
      repeat (DRAIN_CYCLES) @(posedge clock);
      csr_valid       <= 1'b1;
      csr_wall_height <= height;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
   endtask

   function automatic logic [31:0] rand_coord();
      int r;
      r = $urandom_range(0, 9);
      if (r < 5) return 32'($signed($urandom_range(0, 2000000)) - 1000000);
      if (r < 8) return $urandom();
      return r[0] ? 32'h7FFF_FFFF - $urandom_range(0, 3) : 32'h8000_0000 + $urandom_range(0, 3);
   endfunction

   task automatic random_segments(input int count);
      logic [31:0] sx, sy;
      for (int i = 0; i < count; i++) begin
         sx = rand_coord();
         sy = rand_coord();
         // some zero-length segments
         if ($urandom_range(0, 15) == 0)
            send_segment(sx, sy, sx, sy, THICK_W'($urandom()));
         else
            send_segment(sx, sy, rand_coord(), rand_coord(),
                         ($urandom_range(0, 3) == 0) ? THICK_W'($urandom()) :
                         THICK_W'($urandom_range(0, 65536 * 4)));
      end
   endtask

   initial begin
      reset              = 1'b1;
      req_valid          = 1'b0;
      req_start_x        = '0;
      req_start_y        = '0;
      req_end_x          = '0;
      req_end_y          = '0;
      req_wall_thickness = '0;
      csr_valid          = 1'b0;
      csr_wall_height    = '0;
      hold_output        = 1'b0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: reset height, extremes, degenerate and saturating segments
      send_segment(0, 0, 32'h0001_0000, 0, 22'h00_8000);
      send_segment(0, 0, 0, 32'h0003_0000, 22'h3F_FFFF);
      send_segment(32'h0001_0000, 32'h0002_0000, 32'h0001_0000, 32'h0002_0000, 22'h3F_FFFF);
      send_segment(0, 0, 0, 0, 0);
      send_segment(32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 22'h3F_FFFF);
      send_segment(32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF, 22'h3F_FFFF);
      send_segment(32'h7FFF_FFFF, 0, 32'h7FFF_FFFF, 32'h0001_0000, 22'h3F_FFFF);
      send_segment(32'h8000_0000, 0, 32'h8000_0000, 32'h0001_0000, 22'h3F_FFFF);
      send_segment(0, 32'h7FFF_FFFF, 32'hFFFF_0000, 32'h7FFF_FFFF, 22'h3F_FFFF);
      send_segment(0, 32'h8000_0000, 32'h0001_0000, 32'h8000_0000, 22'h3F_FFFF);
      send_segment(32'hFFFF_FFFF, 32'hFFFF_FFFF, 0, 0, 22'h3F_FFFF);
      send_segment(32'h1234_5678, 32'hDEAD_BEEF, 32'hCAFE_0001, 32'h0F0F_0F0F, 22'h15_5555);
      send_segment(32'hAAAA_AAAA, 32'h5555_5555, 32'h5555_5555, 32'hAAAA_AAAA, 22'h2A_AAAA);

      settle_and_write('0);
      send_segment(0, 0, 32'hFFFE_0000, 32'hFFFE_0000, 22'h02_0000);
      random_segments(25);

      settle_and_write(22'h3F_FFFF);
      random_segments(20);
      // block the output and keep offering so the pipeline fills
      hold_output = 1'b1;
      random_segments(30);

      settle_and_write(THICK_W'($urandom()));
      random_segments(25);

      req_valid <= 1'b0;
      @(posedge clock);
      wait (vertices_pending == 0);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatches == 0) $display("tb_wall_segment_to_prism OK");
      else $display("tb_wall_segment_to_prism NOT OK");
      $finish;
   end

endmodule

// ===== filelist.f =====
hdl/wsp_pkg.sv
hdl/wsp_div.sv
hdl/wall_segment_to_prism.sv
hdl/wsp_checker.sv
dv/wall_segment_checker.sv
dv/tb_wall_segment_to_prism.sv
